/* hdl/sidc_pkg.sv */
// Shared constants and types for the signed integer to decimal text unit.
// No dependencies; imported by the top module, sidc_back and the testbench.
`default_nettype none

package sidc_pkg;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam int unsigned BCD_DIGIT_W = 4;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } back_state_t;

  // Decimal digits needed for a magnitude of w bits (log10(2) ~ 0.30103).
  function automatic int unsigned dec_digits(input int unsigned w);
    return (w * 30103) / 100000 + 1;
  endfunction

endpackage

`default_nettype wire

/* hdl/sidc_num_if.sv */
// Input channel of the unit: one signed integer per request.
// Uses no package; the width follows the DATA_WIDTH parameter.
`default_nettype none

interface sidc_num_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

/* hdl/sidc_text_if.sv */
// Output channel of the unit: one ASCII character per request, plus a
// flag on the final character of a number. No dependencies.
`default_nettype none

interface sidc_text_if ();
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

/* hdl/signed_int_to_decimal_ascii_unit.sv */
// Converts signed DATA_WIDTH-bit integers to decimal ASCII text, one
// character per output request, most significant first, with a leading '-'
// for negative values, no leading zeros and last set on the final
// character. A front end takes each number into a two-entry queue; the back
// end converts one number at a time: it loads the number, runs a bit-serial
// shift-and-add-3 loop over its DATA_WIDTH bits, emits the sign if any and
// then steps through each decimal digit position (10 at DATA_WIDTH = 32,
// leading zero positions included). Depends on sidc_pkg, sidc_num_if,
// sidc_text_if, sidc_front, sidc_queue and sidc_back.
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  sidc_num_if.sink    number,
  sidc_text_if.source text
);
  import sidc_pkg::*;

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic [DATA_WIDTH:0] q_wr_data;
  logic [DATA_WIDTH:0] q_rd_data;

  sidc_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .number (number),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  sidc_queue #(
    .WIDTH (DATA_WIDTH + 1)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  sidc_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .text    (text)
  );
endmodule

`default_nettype wire

/* hdl/sidc_front.sv */
// Front end: accepts integers, splits them into sign and unsigned
// magnitude and pushes them into the queue. Depends on sidc_num_if.
`default_nettype none

module sidc_front #(
  parameter int DATA_WIDTH = 32
) (
  sidc_num_if.sink              number,
  input  wire logic             q_full,
  output logic                  q_push,
  output logic [DATA_WIDTH:0]   q_data
);
  logic                  neg;
  logic [DATA_WIDTH-1:0] raw;
  logic [DATA_WIDTH-1:0] mag;

  assign raw = number.value;
  assign neg = raw[DATA_WIDTH-1];
  // Unsigned negation, so the most negative value keeps its full magnitude.
  assign mag = neg ? (~raw + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : raw;

  assign number.ready = ~q_full;
  assign q_push       = number.valid & ~q_full;
  assign q_data       = {neg, mag};
endmodule

`default_nettype wire

/* hdl/sidc_queue.sv */
// Two-entry queue between the front and back ends of the unit.
// Plain registers; no package dependencies.
`default_nettype none

module sidc_queue #(
  parameter int WIDTH = 33
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end
endmodule

`default_nettype wire

/* hdl/sidc_back.sv */
// Back end: bit-serial binary to BCD conversion (shift and add 3), then
// emission of the sign and digits through a registered output stage.
// Depends on sidc_pkg and sidc_text_if.
`default_nettype none

module sidc_back #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire logic [DATA_WIDTH:0] q_data,
  output logic                 q_pop,
  sidc_text_if.source          text
);
  import sidc_pkg::*;

  localparam int ND     = dec_digits(DATA_WIDTH);
  localparam int BCD_W  = ND * BCD_DIGIT_W;
  localparam int CNT_W  = $clog2(DATA_WIDTH);
  localparam int LEFT_W = $clog2(ND + 1);

  back_state_t           state, state_next;
  logic [DATA_WIDTH-1:0] shreg, shreg_next;
  logic [BCD_W-1:0]      bcd, bcd_next;
  logic [BCD_W-1:0]      adj;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic [LEFT_W-1:0]     left, left_next;
  logic                  neg, neg_next;
  logic                  started, started_next;
  logic                  text_valid, text_valid_next;
  logic [7:0]            chr, chr_next;
  logic                  lst, lst_next;
  logic                  slot_free;
  logic                  emit;
  logic [7:0]            emit_char;
  logic                  emit_last;
  logic [3:0]            top;

  assign slot_free = ~text_valid | text.ready;
  assign top       = bcd[BCD_W-1 -: BCD_DIGIT_W];

  // Add 3 to every digit of 5 or more before each shift.
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd[i*BCD_DIGIT_W +: BCD_DIGIT_W] >= 4'd5) begin
        adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] = bcd[i*BCD_DIGIT_W +: BCD_DIGIT_W] + 4'd3;
      end else begin
        adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] = bcd[i*BCD_DIGIT_W +: BCD_DIGIT_W];
      end
    end
  end

  always_comb begin
    state_next   = state;
    shreg_next   = shreg;
    bcd_next     = bcd;
    cnt_next     = cnt;
    left_next    = left;
    neg_next     = neg;
    started_next = started;
    q_pop        = 1'b0;
    emit         = 1'b0;
    emit_char    = ASCII_ZERO + {4'd0, top};
    emit_last    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          neg_next   = q_data[DATA_WIDTH];
          shreg_next = q_data[DATA_WIDTH-1:0];
          bcd_next   = '0;
          cnt_next   = CNT_W'(DATA_WIDTH - 1);
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_next   = {adj[BCD_W-2:0], shreg[DATA_WIDTH-1]};
        shreg_next = {shreg[DATA_WIDTH-2:0], 1'b0};
        if (cnt == '0) begin
          left_next    = LEFT_W'(ND);
          started_next = 1'b0;
          state_next   = neg ? ST_SIGN : ST_EMIT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_char  = ASCII_MINUS;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (left == LEFT_W'(1)) begin
          // The units digit always goes out, which covers a zero value.
          if (slot_free) begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (top == 4'd0 && !started) begin
          bcd_next  = {bcd[BCD_W-BCD_DIGIT_W-1:0], 4'd0};
          left_next = left - 1'b1;
        end else if (slot_free) begin
          emit         = 1'b1;
          started_next = 1'b1;
          bcd_next     = {bcd[BCD_W-BCD_DIGIT_W-1:0], 4'd0};
          left_next    = left - 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    text_valid_next = text_valid;
    chr_next        = chr;
    lst_next        = lst;
    if (slot_free) begin
      text_valid_next = emit;
      if (emit) begin
        chr_next = emit_char;
        lst_next = emit_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      text_valid <= 1'b0;
      started    <= 1'b0;
    end else begin
      state      <= state_next;
      text_valid <= text_valid_next;
      started    <= started_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg <= shreg_next;
    bcd   <= bcd_next;
    cnt   <= cnt_next;
    left  <= left_next;
    neg   <= neg_next;
    chr   <= chr_next;
    lst   <= lst_next;
  end

  assign text.valid     = text_valid;
  assign text.character = chr;
  assign text.last      = lst;
endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Testbench for the signed integer to decimal text unit: random and directed
// numbers in, every character checked against an in-bench predictor.
// Depends on sidc_pkg, sidc_num_if, sidc_text_if and the unit's RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sidc_pkg::*;

  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_COUNT = 98;
  localparam int CYCLE_LIMIT  = 150000;
  localparam int HOLD_AT      = 30;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_FROM   = 70;
  localparam int QUIET_TO     = 100;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic clk;
  logic rst;

  sidc_num_if #(.DATA_WIDTH(DATA_WIDTH)) number_ch ();
  sidc_text_if text_ch ();

  signed_int_to_decimal_ascii_unit #(.DATA_WIDTH(DATA_WIDTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .number (number_ch),
    .text   (text_ch)
  );

  logic signed [DATA_WIDTH-1:0] pending_numbers[$];
  text_char_t                   expected_chars[$];

  int error_count;
  int numbers_sent;
  int chars_seen;
  int negatives_sent;
  int longest_text;
  int cycle_count;
  int hold_left;
  bit hold_done;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("[%0t] character %0d: %s", $realtime, chars_seen, what);
    end
  endtask

  // Decimal text of one number, most significant character first.
  function automatic void predict_text(input logic signed [DATA_WIDTH-1:0] num);
    logic [DATA_WIDTH-1:0] mag;
    logic [3:0]            digits[10];
    int                    count;
    int                    k;
    text_char_t            c;
    mag = num[DATA_WIDTH-1] ? (~num + 1'b1) : num;
    count = 0;
    do begin
      digits[count] = 4'(mag % 10);
      count++;
      mag = mag / 10;
    end while (mag != 0);
    if (num[DATA_WIDTH-1]) begin
      c.character = ASCII_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
      negatives_sent++;
    end
    for (k = count - 1; k >= 0; k--) begin
      c.character = ASCII_ZERO + 8'(digits[k]);
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
    if (count + num[DATA_WIDTH-1] > longest_text) begin
      longest_text = count + num[DATA_WIDTH-1];
    end
  endfunction

  function automatic bit quiet_window();
    return numbers_sent >= QUIET_FROM && numbers_sent < QUIET_TO;
  endfunction

  // Sender: a request stays up until it is taken, then the next one follows.
  always @(posedge clk) begin
    if (rst) begin
      number_ch.valid <= 1'b0;
      number_ch.value <= '0;
    end else begin
      if (number_ch.valid && number_ch.ready) begin
        predict_text(number_ch.value);
        numbers_sent++;
      end
      if (!number_ch.valid || number_ch.ready) begin
        if (pending_numbers.size() != 0 &&
            (quiet_window() || $urandom_range(0, 99) >= 10)) begin
          number_ch.valid <= 1'b1;
          number_ch.value <= pending_numbers.pop_front();
        end else begin
          number_ch.valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering numbers.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && numbers_sent >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each character request against the oldest expectation.
  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      text_ch.ready <= 1'b0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                    text_ch.character, text_ch.last));
        end else begin
          want = expected_chars.pop_front();
          if (text_ch.character !== want.character) begin
            report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                      text_ch.character, want.character));
          end
          if (text_ch.last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b",
                                      text_ch.last, want.last));
          end
        end
        chars_seen++;
      end
      if (hold_left != 0) begin
        text_ch.ready <= 1'b0;
      end else begin
        text_ch.ready <= quiet_window() || $urandom_range(0, 99) >= 10;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_count, expected_chars.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic signed [DATA_WIDTH-1:0] num;
    logic [DATA_WIDTH-1:0]        mag;
    logic [DATA_WIDTH-1:0]        pow10;
    int                           k;
    int                           i;
    logic signed [DATA_WIDTH-1:0] directed[] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd5, -32'sd7, 32'sd9, 32'sd10, -32'sd10,
      32'sd99, 32'sd100, -32'sd100, 32'sd12345, -32'sd67890, 32'sd999999999,
      32'sd1000000000, -32'sd1000000000, 32'h7FFF_FFFF, -32'sh7FFF_FFFF,
      32'h8000_0000, 32'h7FFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA
    };

    rst = 1'b1;
    number_ch.valid = 1'b0;
    number_ch.value = '0;
    text_ch.ready = 1'b0;
    error_count = 0;
    numbers_sent = 0;
    chars_seen = 0;
    negatives_sent = 0;
    longest_text = 0;
    cycle_count = 0;

    foreach (directed[j]) pending_numbers.push_back(directed[j]);

    // Mix of full-width values, values of every digit count, neighbors of
    // powers of ten and values with a random number of leading zero bits.
    for (i = 0; i < RANDOM_COUNT; i++) begin
      k = $urandom_range(1, 9);
      pow10 = 1;
      repeat (k) pow10 = pow10 * 10;
      case ($urandom_range(0, 3))
        0: mag = $urandom();
        1: mag = $urandom_range(0, pow10 - 1);
        2: mag = pow10 + $urandom_range(0, 2) - 1;
        default: mag = $urandom() >> $urandom_range(0, DATA_WIDTH - 1);
      endcase
      num = $urandom_range(0, 1) ? -mag : mag;
      pending_numbers.push_back(num);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_numbers.size() != 0 || number_ch.valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d numbers (%0d negative), %0d characters, longest text %0d",
             numbers_sent, negatives_sent, chars_seen, longest_text);
    $display("one receiver hold-off of %0d cycles, finished in %0d cycles",
             HOLD_CYCLES, cycle_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hdl/sidc_pkg.sv
hdl/sidc_num_if.sv
hdl/sidc_text_if.sv
hdl/sidc_front.sv
hdl/sidc_queue.sv
hdl/sidc_back.sv
hdl/signed_int_to_decimal_ascii_unit.sv
sim/tb_top.sv
